// File: hdl/hsvpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvpw_pkg
// Shared types and constants for the HSV-to-RGB pixel writer pipeline.
// ----------------------------------------------------------------------------
package hsvpw_pkg;

  localparam int NUM_STAGES = 5;

  // Per-stage load strobes handed from the control in the top level
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } hsvpw_ctrl_t;

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [8:0] DEG_60   = 9'd60;
  localparam logic [8:0] DEG_120  = 9'd120;
  localparam logic [8:0] DEG_180  = 9'd180;
  localparam logic [8:0] DEG_240  = 9'd240;
  localparam logic [8:0] DEG_300  = 9'd300;

  // floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for x < 23831
  localparam logic [14:0] RECIP_60    = 15'd17477;
  localparam int          RECIP_SHIFT = 20;

  localparam logic [12:0] WIDTH_RESET = 13'd1024;

endpackage

// File: hdl/hsvpw_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvpw_color
// Five-stage HSV-to-RGB color datapath: chroma, secondary, offset and the
// sector-based component ordering.
// ----------------------------------------------------------------------------
module hsvpw_color (
  input  logic               clk,
  input  hsvpw_pkg::hsvpw_ctrl_t ctrl,
  input  logic [8:0]         hue_degrees,
  input  logic [7:0]         saturation,
  input  logic [7:0]         brightness,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  // stage 1
  logic [15:0]             s1_vs_r;
  hsvpw_pkg::sector_t      s1_sec_r;
  logic [5:0]              s1_fac_r;
  logic [7:0]              s1_val_r;
  // stage 2
  logic [7:0]              s2_chroma_r;
  hsvpw_pkg::sector_t      s2_sec_r;
  logic [5:0]              s2_fac_r;
  logic [7:0]              s2_val_r;
  // stage 3
  logic [13:0]             s3_sprod_r;
  logic [7:0]              s3_chroma_r;
  logic [7:0]              s3_offset_r;
  hsvpw_pkg::sector_t      s3_sec_r;
  // stage 4
  logic [7:0]              s4_second_r;
  logic [7:0]              s4_chroma_r;
  logic [7:0]              s4_offset_r;
  hsvpw_pkg::sector_t      s4_sec_r;
  // stage 5
  logic [7:0]              red_r, green_r, blue_r;

  logic [8:0]              hue_w;
  logic [8:0]              hue_m;
  hsvpw_pkg::sector_t      sec_nxt;
  logic [5:0]              fac_nxt;
  logic [16:0]             div_sum;
  logic [28:0]             recip_prod;
  logic [7:0]              r_nxt, g_nxt, b_nxt;

  // Hue wrap, sector pick and the triangle factor 60-|hue mod 120 - 60|
  always_comb begin
    hue_w = (hue_degrees >= hsvpw_pkg::HUE_WRAP) ? hue_degrees - hsvpw_pkg::HUE_WRAP
                                                 : hue_degrees;
    if (hue_w < hsvpw_pkg::DEG_60)       sec_nxt = hsvpw_pkg::SEC_RED_YEL;
    else if (hue_w < hsvpw_pkg::DEG_120) sec_nxt = hsvpw_pkg::SEC_YEL_GRN;
    else if (hue_w < hsvpw_pkg::DEG_180) sec_nxt = hsvpw_pkg::SEC_GRN_CYN;
    else if (hue_w < hsvpw_pkg::DEG_240) sec_nxt = hsvpw_pkg::SEC_CYN_BLU;
    else if (hue_w < hsvpw_pkg::DEG_300) sec_nxt = hsvpw_pkg::SEC_BLU_MAG;
    else                                 sec_nxt = hsvpw_pkg::SEC_MAG_RED;

    if (hue_w < hsvpw_pkg::DEG_120)      hue_m = hue_w;
    else if (hue_w < hsvpw_pkg::DEG_240) hue_m = hue_w - hsvpw_pkg::DEG_120;
    else                                 hue_m = hue_w - hsvpw_pkg::DEG_240;

    fac_nxt = (hue_m >= hsvpw_pkg::DEG_60) ? 6'(hsvpw_pkg::DEG_120 - hue_m) : 6'(hue_m);
  end

  // p / 255 == (p + (p >> 8) + 1) >> 8 for every p up to 65534
  assign div_sum    = {1'b0, s1_vs_r} + {9'd0, s1_vs_r[15:8]} + 17'd1;
  assign recip_prod = {15'd0, s3_sprod_r} * {14'd0, hsvpw_pkg::RECIP_60};

  always_comb begin
    r_nxt = '0;
    g_nxt = '0;
    b_nxt = '0;
    case (s4_sec_r)
      hsvpw_pkg::SEC_RED_YEL: begin r_nxt = s4_chroma_r; g_nxt = s4_second_r; end
      hsvpw_pkg::SEC_YEL_GRN: begin r_nxt = s4_second_r; g_nxt = s4_chroma_r; end
      hsvpw_pkg::SEC_GRN_CYN: begin g_nxt = s4_chroma_r; b_nxt = s4_second_r; end
      hsvpw_pkg::SEC_CYN_BLU: begin g_nxt = s4_second_r; b_nxt = s4_chroma_r; end
      hsvpw_pkg::SEC_BLU_MAG: begin r_nxt = s4_second_r; b_nxt = s4_chroma_r; end
      default:                begin r_nxt = s4_chroma_r; b_nxt = s4_second_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      s1_vs_r  <= {8'd0, brightness} * {8'd0, saturation};
      s1_sec_r <= sec_nxt;
      s1_fac_r <= fac_nxt;
      s1_val_r <= brightness;
    end
    if (ctrl.adv[1]) begin
      s2_chroma_r <= div_sum[15:8];
      s2_sec_r    <= s1_sec_r;
      s2_fac_r    <= s1_fac_r;
      s2_val_r    <= s1_val_r;
    end
    if (ctrl.adv[2]) begin
      s3_sprod_r  <= {6'd0, s2_chroma_r} * {8'd0, s2_fac_r};
      s3_chroma_r <= s2_chroma_r;
      s3_offset_r <= s2_val_r - s2_chroma_r;
      s3_sec_r    <= s2_sec_r;
    end
    if (ctrl.adv[3]) begin
      s4_second_r <= recip_prod[hsvpw_pkg::RECIP_SHIFT +: 8];
      s4_chroma_r <= s3_chroma_r;
      s4_offset_r <= s3_offset_r;
      s4_sec_r    <= s3_sec_r;
    end
    if (ctrl.adv[4]) begin
      red_r   <= r_nxt + s4_offset_r;
      green_r <= g_nxt + s4_offset_r;
      blue_r  <= b_nxt + s4_offset_r;
    end
  end

  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule

// File: hdl/hsvpw_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvpw_index
// Linear pixel index y*width+x, clamped and pipelined in step with the
// color datapath.
// ----------------------------------------------------------------------------
module hsvpw_index #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  hsvpw_pkg::hsvpw_ctrl_t ctrl,
  input  logic [12:0]        image_width,
  input  logic [11:0]        pixel_x,
  input  logic [11:0]        pixel_y,
  output logic [23:0]        pixel_index
);

  logic [12:0] s1_w_r;
  logic [11:0] s1_x_r, s1_y_r;
  logic [24:0] s2_prod_r;
  logic [11:0] s2_x_r;
  logic [23:0] s3_idx_r, s4_idx_r, s5_idx_r;

  logic [12:0] w_nxt;
  logic [11:0] x_nxt, y_nxt;
  logic [24:0] sum;

  // Saturate width and coordinates to the supported image size
  always_comb begin
    w_nxt = (int'(image_width) > MAX_WIDTH) ? 13'(MAX_WIDTH) : image_width;
    x_nxt = (int'(pixel_x) > MAX_WIDTH - 1) ? 12'(MAX_WIDTH - 1) : pixel_x;
    y_nxt = (int'(pixel_y) > MAX_HEIGHT - 1) ? 12'(MAX_HEIGHT - 1) : pixel_y;
  end

  assign sum = s2_prod_r + {13'd0, s2_x_r};

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      s1_w_r <= w_nxt;
      s1_x_r <= x_nxt;
      s1_y_r <= y_nxt;
    end
    if (ctrl.adv[1]) begin
      s2_prod_r <= {13'd0, s1_y_r} * {12'd0, s1_w_r};
      s2_x_r    <= s1_x_r;
    end
    if (ctrl.adv[2]) s3_idx_r <= sum[23:0];
    if (ctrl.adv[3]) s4_idx_r <= s3_idx_r;
    if (ctrl.adv[4]) s5_idx_r <= s4_idx_r;
  end

  assign pixel_index = s5_idx_r;

endmodule

// File: hdl/hsv_to_rgb_pixel_writer_core.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle when not stalled; five registered stages,
//   the longest step being one 8x8, 12x13 or 14x15 multiply per stage.
// Stalls back up stage by stage; empty stages keep loading, nothing drops.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets
//   image_width to 1024.
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_writer_core
// Streaming HSV-to-RGB converter that also produces the linear pixel index.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_writer_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,      // image_width
  input  logic        in_tvalid,
  output logic        in_tready,
  // [8:0] hue_degrees, [16:9] saturation, [24:17] brightness,
  // [36:25] pixel_x, [48:37] pixel_y, [55:49] unused
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [47:24] pixel_index
  output logic [47:0] out_tdata
);

  localparam int NS = hsvpw_pkg::NUM_STAGES;

  logic [12:0]           image_width_r;
  logic [NS-1:0]         vld_r;
  logic [NS:0]           rdy;
  logic [NS-1:0]         vld_in;
  hsvpw_pkg::hsvpw_ctrl_t ctrl;
  logic [7:0]            red, green, blue;
  logic [23:0]           pixel_index;

  // A stage loads when empty or when the stage after it moves on
  always_comb begin
    rdy[NS] = out_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_in = {vld_r[NS-2:0], in_tvalid};
    ctrl.adv = rdy[NS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= hsvpw_pkg::WIDTH_RESET;
      vld_r         <= '0;
    end else begin
      if (cfg_we) image_width_r <= cfg_wdata;
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld_r[k] <= vld_in[k];
      end
    end
  end

  hsvpw_color u_color (
    .clk         (clk),
    .ctrl        (ctrl),
    .hue_degrees (in_tdata[8:0]),
    .saturation  (in_tdata[16:9]),
    .brightness  (in_tdata[24:17]),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  hsvpw_index #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_index (
    .clk         (clk),
    .ctrl        (ctrl),
    .image_width (image_width_r),
    .pixel_x     (in_tdata[36:25]),
    .pixel_y     (in_tdata[48:37]),
    .pixel_index (pixel_index)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {pixel_index, blue, green, red};

endmodule
